@@ design/bsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfc_pkg
// shared types, widths and codes of the bar series fractal classifier
// ----------------------------------------------------------------------------
package bsfc_pkg;

   localparam int MAX_BARS    = 1024;
   localparam int ADDR_W      = $clog2(MAX_BARS);
   localparam int CNT_W       = $clog2(MAX_BARS + 1);
   localparam int PRICE_W     = 32;
   localparam int INDEX_W     = 10;
   localparam int BAR_COUNT_W = 11;
   localparam int LEVEL_W     = 3;
   localparam int STATUS_W    = 2;
   localparam int REQ_W       = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(5);

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_INTERIOR = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [PRICE_W-1:0] bar_high;
      logic [PRICE_W-1:0] bar_low;
      logic [INDEX_W-1:0] bar_index;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]     bottom_level;
      logic [LEVEL_W-1:0]     top_level;
      logic [STATUS_W-1:0]    status;
      logic [BAR_COUNT_W-1:0] bar_count;
   } rsp_word_type;

   typedef struct packed {
      logic [PRICE_W-1:0] high;
      logic [PRICE_W-1:0] low;
   } bar_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      bar_type           bar;
   } bar_wr_type;

   // a is beyond b in the walk direction: above for a bottom, below for a top
   function automatic logic beyond(input logic top, input logic [PRICE_W-1:0] a,
                                   input logic [PRICE_W-1:0] b);
      beyond = top ? (a < b) : (a > b);
   endfunction

endpackage

@@ design/bsfc_bar_store.sv @@
// ----------------------------------------------------------------------------
// bsfc_bar_store
// bar table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bsfc_bar_store (
   input  logic                          clock,
   input  bsfc_pkg::bar_wr_type          wr,
   input  logic [bsfc_pkg::ADDR_W-1:0]   rd_addr,
   output bsfc_pkg::bar_type             rd_bar
);

   bsfc_pkg::bar_type bar_mem [bsfc_pkg::MAX_BARS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         bar_mem[wr.addr] <= wr.bar;
      end
      rd_bar <= bar_mem[rd_addr];
   end

endmodule

@@ design/bar_series_fractal_classifier_top.sv @@
// ----------------------------------------------------------------------------
// bar_series_fractal_classifier_top
// keeps a table of price bars and classifies one bar as bottom and top fractal
// ----------------------------------------------------------------------------
//
//   channel | ports                         | direction | word
//   --------+-------------------------------+-----------+----------------------
//   request | req_valid req_ready req_word  | in        | req_type, prices, index
//   result  | rsp_valid rsp_ready rsp_word  | out       | levels, status, count
//
// clear, append, out-of-range query and unknown code: straight from idle to the done state
// interior query: one stored bar per cycle through the single read port of the bar
//   table (back and forward walk for the bottom kind, then again for the top kind)
// reset clears the bar count, the state and the result valid; the table needs no clearing pass
// a finished result waits in the output register while the next word is taken
// one word is in work at a time; the next is taken once its result is registered

module bar_series_fractal_classifier_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bsfc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bsfc_pkg::rsp_word_type rsp_word
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,   // waiting for a request word
      ST_CTR  = 7'b0000010,   // center bar arriving
      ST_PREV = 7'b0000100,   // bar before center arriving
      ST_NEXT = 7'b0001000,   // bar after center arriving
      ST_BACK = 7'b0010000,   // backward walk, one bar per cycle
      ST_FWD  = 7'b0100000,   // forward walk, one bar per cycle
      ST_DONE = 7'b1000000    // result waits for the output register
   } state_type;

   state_type state_ff, state_in;

   logic [bsfc_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bsfc_pkg::rsp_word_type        rsp_ff, rsp_in;

   // query context
   logic [bsfc_pkg::ADDR_W-1:0]   idx_ff, idx_in;
   logic [bsfc_pkg::ADDR_W-1:0]   k_ff, k_in;
   logic [bsfc_pkg::PRICE_W-1:0]  ctr_hi_ff, ctr_hi_in;
   logic [bsfc_pkg::PRICE_W-1:0]  ctr_lo_ff, ctr_lo_in;
   logic [bsfc_pkg::PRICE_W-1:0]  c_pri_ff, c_pri_in;
   logic [bsfc_pkg::PRICE_W-1:0]  c_sec_ff, c_sec_in;
   logic                          bot_ok_ff, bot_ok_in;
   logic                          top_ok_ff, top_ok_in;
   logic                          kind_ff, kind_in;     // 0 bottom, 1 top
   logic [bsfc_pkg::LEVEL_W-1:0]  back_ff, back_in;     // saturates at level max
   logic [bsfc_pkg::LEVEL_W-1:0]  fwd_ff, fwd_in;
   logic [bsfc_pkg::LEVEL_W-1:0]  bot_lvl_ff, bot_lvl_in;
   logic [bsfc_pkg::LEVEL_W-1:0]  top_lvl_ff, top_lvl_in;
   logic [bsfc_pkg::STATUS_W-1:0] status_ff, status_in;

   // bar table ports
   bsfc_pkg::bar_wr_type          wr;
   logic [bsfc_pkg::ADDR_W-1:0]   rd_addr;
   bsfc_pkg::bar_type             rd_bar;

   // walk compares on the bar just read
   logic [bsfc_pkg::PRICE_W-1:0]  pri_k, sec_k;
   logic                          step_pri, step_sec, step_gap;
   logic [bsfc_pkg::CNT_W-1:0]    idx_cnt;
   logic                          interior;
   logic                          req_fire, rsp_load;

   // walk control
   logic                          begin_walk, begin_kind, finish_kind;
   logic [bsfc_pkg::LEVEL_W-1:0]  kind_lvl, back_nx, fwd_nx;

   bsfc_bar_store u_bar_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_bar  (rd_bar)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // price roles swap for the top kind
   assign pri_k    = kind_ff ? rd_bar.high : rd_bar.low;
   assign sec_k    = kind_ff ? rd_bar.low  : rd_bar.high;
   assign step_pri = bsfc_pkg::beyond(kind_ff, pri_k, c_pri_ff);
   assign step_sec = bsfc_pkg::beyond(kind_ff, sec_k, c_sec_ff);
   assign step_gap = bsfc_pkg::beyond(kind_ff, pri_k, c_sec_ff);

   // interior: 0 < index < count - 1, needs at least three bars
   assign idx_cnt  = bsfc_pkg::CNT_W'(req_word.bar_index);
   assign interior = (idx_cnt != '0) && (fill_ff >= bsfc_pkg::CNT_W'(3)) &&
                     (idx_cnt < fill_ff - bsfc_pkg::CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      ctr_hi_in    = ctr_hi_ff;
      ctr_lo_in    = ctr_lo_ff;
      c_pri_in     = c_pri_ff;
      c_sec_in     = c_sec_ff;
      bot_ok_in    = bot_ok_ff;
      top_ok_in    = top_ok_ff;
      kind_in      = kind_ff;
      back_in      = back_ff;
      fwd_in       = fwd_ff;
      bot_lvl_in   = bot_lvl_ff;
      top_lvl_in   = top_lvl_ff;
      status_in    = status_ff;
      wr           = '0;
      rd_addr      = k_ff;
      begin_walk   = 1'b0;
      begin_kind   = 1'b0;
      finish_kind  = 1'b0;
      kind_lvl     = '0;
      back_nx      = back_ff;
      fwd_nx       = fwd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in     = bsfc_pkg::ADDR_W'(req_word.bar_index);
               bot_lvl_in = '0;
               top_lvl_in = '0;
               status_in  = bsfc_pkg::STATUS_OK;
               state_in   = ST_DONE;
               case (req_word.req_type)
                  bsfc_pkg::REQ_CLEAR: begin
                     fill_in = '0;
                  end
                  bsfc_pkg::REQ_APPEND: begin
                     if (fill_ff >= bsfc_pkg::CNT_W'(bsfc_pkg::MAX_BARS)) begin
                        status_in = bsfc_pkg::STATUS_FULL;
                     end else begin
                        wr.en       = 1'b1;
                        wr.addr     = fill_ff[bsfc_pkg::ADDR_W-1:0];
                        wr.bar.high = req_word.bar_high;
                        wr.bar.low  = req_word.bar_low;
                        fill_in     = fill_ff + bsfc_pkg::CNT_W'(1);
                     end
                  end
                  bsfc_pkg::REQ_QUERY: begin
                     if (interior) begin
                        rd_addr  = bsfc_pkg::ADDR_W'(req_word.bar_index);
                        state_in = ST_CTR;
                     end else begin
                        status_in = bsfc_pkg::STATUS_NOT_INTERIOR;
                     end
                  end
                  default: begin
                     // unknown code: plain ok result
                  end
               endcase
            end
         end
         ST_CTR: begin
            ctr_hi_in = rd_bar.high;
            ctr_lo_in = rd_bar.low;
            rd_addr   = idx_ff - bsfc_pkg::ADDR_W'(1);
            state_in  = ST_PREV;
         end
         ST_PREV: begin
            bot_ok_in = !bsfc_pkg::beyond(1'b0, ctr_lo_ff, rd_bar.low);
            top_ok_in = !bsfc_pkg::beyond(1'b1, ctr_hi_ff, rd_bar.high);
            rd_addr   = idx_ff + bsfc_pkg::ADDR_W'(1);
            state_in  = ST_NEXT;
         end
         ST_NEXT: begin
            bot_ok_in = bot_ok_ff && !bsfc_pkg::beyond(1'b0, ctr_lo_ff, rd_bar.low);
            top_ok_in = top_ok_ff && !bsfc_pkg::beyond(1'b1, ctr_hi_ff, rd_bar.high);
            if (idx_ff == bsfc_pkg::ADDR_W'(1)) begin
               // bar 0 is never walked, so both levels stay zero
               state_in = ST_DONE;
            end else if (bot_ok_in) begin
               begin_walk = 1'b1;
               begin_kind = 1'b0;
            end else if (top_ok_in) begin
               begin_walk = 1'b1;
               begin_kind = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BACK: begin
            if (step_pri && step_sec) begin
               back_nx  = (back_ff == bsfc_pkg::LEVEL_MAX) ? back_ff
                                                           : back_ff + bsfc_pkg::LEVEL_W'(1);
               c_pri_in = pri_k;
               c_sec_in = sec_k;
            end
            back_in = back_nx;
            if (step_pri && (k_ff != bsfc_pkg::ADDR_W'(1))) begin
               k_in    = k_ff - bsfc_pkg::ADDR_W'(1);
               rd_addr = k_in;
            end else if (back_nx == '0) begin
               finish_kind = 1'b1;
            end else begin
               // forward walk restarts from the center bar
               c_pri_in = kind_ff ? ctr_hi_ff : ctr_lo_ff;
               c_sec_in = kind_ff ? ctr_lo_ff : ctr_hi_ff;
               k_in     = idx_ff + bsfc_pkg::ADDR_W'(1);
               rd_addr  = k_in;
               fwd_in   = '0;
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            // gap bars are passed over without moving the reference
            if (step_pri && !step_gap && step_sec) begin
               fwd_nx   = (fwd_ff == bsfc_pkg::LEVEL_MAX) ? fwd_ff
                                                         : fwd_ff + bsfc_pkg::LEVEL_W'(1);
               c_pri_in = pri_k;
               c_sec_in = sec_k;
            end
            fwd_in = fwd_nx;
            if (step_pri &&
                (bsfc_pkg::CNT_W'(k_ff) != fill_ff - bsfc_pkg::CNT_W'(1))) begin
               k_in    = k_ff + bsfc_pkg::ADDR_W'(1);
               rd_addr = k_in;
            end else begin
               finish_kind = 1'b1;
               if (fwd_nx != '0) begin
                  kind_lvl = (back_ff < fwd_nx) ? back_ff : fwd_nx;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_in.bottom_level = bot_lvl_ff;
               rsp_in.top_level    = top_lvl_ff;
               rsp_in.status       = status_ff;
               rsp_in.bar_count    = bsfc_pkg::BAR_COUNT_W'(fill_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // end of one kind: record its level, then the top kind or the result
      if (finish_kind) begin
         if (kind_ff) begin
            top_lvl_in = kind_lvl;
            state_in   = ST_DONE;
         end else begin
            bot_lvl_in = kind_lvl;
            if (top_ok_ff) begin
               begin_walk = 1'b1;
               begin_kind = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
      end

      // start a backward walk from the center bar
      if (begin_walk) begin
         kind_in  = begin_kind;
         c_pri_in = begin_kind ? ctr_hi_ff : ctr_lo_ff;
         c_sec_in = begin_kind ? ctr_lo_ff : ctr_hi_ff;
         k_in     = idx_ff - bsfc_pkg::ADDR_W'(1);
         rd_addr  = k_in;
         back_in  = '0;
         fwd_in   = '0;
         state_in = ST_BACK;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and query context
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      ctr_hi_ff  <= ctr_hi_in;
      ctr_lo_ff  <= ctr_lo_in;
      c_pri_ff   <= c_pri_in;
      c_sec_ff   <= c_sec_in;
      bot_ok_ff  <= bot_ok_in;
      top_ok_ff  <= top_ok_in;
      kind_ff    <= kind_in;
      back_ff    <= back_in;
      fwd_ff     <= fwd_in;
      bot_lvl_ff <= bot_lvl_in;
      top_lvl_ff <= top_lvl_in;
      status_ff  <= status_in;
   end

   // bar count never passes the table depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= bsfc_pkg::CNT_W'(bsfc_pkg::MAX_BARS))
      else $error("bar count beyond table depth");

   // an append into a table with room grows the count by one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_word.req_type == bsfc_pkg::REQ_APPEND) &&
      (fill_ff != bsfc_pkg::CNT_W'(bsfc_pkg::MAX_BARS))
      |=> fill_ff == $past(fill_ff) + bsfc_pkg::CNT_W'(1))
      else $error("append did not grow the bar count");

   // walks only touch written bars
   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BACK || state_ff == ST_FWD)
      |-> bsfc_pkg::CNT_W'(k_ff) < fill_ff)
      else $error("walk position outside the filled table");

   // levels stay in range and are zero on any status but ok
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.bottom_level <= bsfc_pkg::LEVEL_MAX) &&
                       (rsp_ff.top_level <= bsfc_pkg::LEVEL_MAX) &&
                       ((rsp_ff.status == bsfc_pkg::STATUS_OK) ||
                        (rsp_ff.bottom_level == '0 && rsp_ff.top_level == '0)))
      else $error("result level out of range");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bar series fractal classifier: words go in
// through a bursty sender, results come back through a stalling receiver, and
// a behavioral copy of the bar table predicts every result word in order
// ----------------------------------------------------------------------------
module tb;

   // code with no meaning to the block, still answered with one word
   localparam logic [bsfc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
   // rough number of words that the random part sends
   localparam int SERIES_ITEMS = 250;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   bsfc_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   bsfc_pkg::rsp_word_type rsp_word;

   // behavioral copy of the bar table and its fill count
   logic [bsfc_pkg::PRICE_W-1:0] bar_hi [bsfc_pkg::MAX_BARS];
   logic [bsfc_pkg::PRICE_W-1:0] bar_lo [bsfc_pkg::MAX_BARS];
   int                           bars_held = 0;

   // result words predicted but not yet seen, oldest first
   bsfc_pkg::rsp_word_type expected_results [$];
   int                     fail_count = 0;

   // sender bursts and receiver stall pattern
   bit          gaps_on     = 1'b1;
   int          burst_left  = 0;
   bit          stalls_on   = 1'b1;
   logic [15:0] stall_pat   = 16'hffff;
   logic [3:0]  stall_phase = 4'd0;

   bar_series_fractal_classifier_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // prices seen from the walk direction: for a top kind both prices are
   // inverted, so "further out" is always a plain unsigned greater-than
   function automatic logic [bsfc_pkg::PRICE_W-1:0] extreme_px(input int k, input bit top);
      return top ? ~bar_hi[k] : bar_lo[k];
   endfunction

   function automatic logic [bsfc_pkg::PRICE_W-1:0] other_px(input int k, input bit top);
      return top ? ~bar_lo[k] : bar_hi[k];
   endfunction

   // fractal level of one kind at an interior bar
   function automatic logic [bsfc_pkg::LEVEL_W-1:0] fractal_level(input int idx,
                                                                   input bit top);
      int back_run;
      int fwd_run;
      int anchor;
      int run;
      back_run = 0;
      fwd_run  = 0;
      // the bar itself must be the local extreme
      if (extreme_px(idx, top) > extreme_px(idx - 1, top) ||
          extreme_px(idx, top) > extreme_px(idx + 1, top))
         return '0;
      // backward walk stops short of bar 0
      anchor = idx;
      for (int k = idx - 1; k > 0; k--) begin
         if (!(extreme_px(k, top) > extreme_px(anchor, top)))
            break;
         if (other_px(k, top) > other_px(anchor, top)) begin
            back_run++;
            anchor = k;
         end
      end
      if (back_run == 0)
         return '0;
      // forward walk skips bars that jump clear of the anchor bar
      anchor = idx;
      for (int k = idx + 1; k < bars_held; k++) begin
         if (!(extreme_px(k, top) > extreme_px(anchor, top)))
            break;
         if (extreme_px(k, top) > other_px(anchor, top))
            continue;
         if (other_px(k, top) > other_px(anchor, top)) begin
            fwd_run++;
            anchor = k;
         end
      end
      if (fwd_run == 0)
         return '0;
      run = (back_run < fwd_run) ? back_run : fwd_run;
      if (run > int'(bsfc_pkg::LEVEL_MAX))
         return bsfc_pkg::LEVEL_MAX;
      return bsfc_pkg::LEVEL_W'(run);
   endfunction

   // updates the table copy for one accepted word and returns its result
   function automatic bsfc_pkg::rsp_word_type compute_response(
      input bsfc_pkg::req_word_type w);
      bsfc_pkg::rsp_word_type r;
      int                     idx;
      r   = '0;
      idx = int'(w.bar_index);
      case (w.req_type)
         bsfc_pkg::REQ_CLEAR: begin
            bars_held = 0;
         end
         bsfc_pkg::REQ_APPEND: begin
            if (bars_held >= bsfc_pkg::MAX_BARS) begin
               r.status = bsfc_pkg::STATUS_FULL;
            end else begin
               bar_hi[bars_held] = w.bar_high;
               bar_lo[bars_held] = w.bar_low;
               bars_held++;
            end
         end
         bsfc_pkg::REQ_QUERY: begin
            if (idx == 0 || bars_held < 3 || idx >= bars_held - 1) begin
               r.status = bsfc_pkg::STATUS_NOT_INTERIOR;
            end else begin
               r.bottom_level = fractal_level(idx, 1'b0);
               r.top_level    = fractal_level(idx, 1'b1);
            end
         end
         default: begin
         end
      endcase
      r.bar_count = bsfc_pkg::BAR_COUNT_W'(bars_held);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   function automatic bsfc_pkg::req_word_type make_word(
      input logic [bsfc_pkg::REQ_W-1:0]   kind,
      input logic [bsfc_pkg::PRICE_W-1:0] hi,
      input logic [bsfc_pkg::PRICE_W-1:0] lo,
      input int                           idx);
      bsfc_pkg::req_word_type w;
      w.req_type  = kind;
      w.bar_high  = hi;
      w.bar_low   = lo;
      w.bar_index = bsfc_pkg::INDEX_W'(idx);
      return w;
   endfunction

   // drives one word at the falling edge and holds it until taken; valid is
   // only lowered at the start of a gap, never in the step that raises it
   task automatic send_word(input bsfc_pkg::req_word_type w);
      bsfc_pkg::rsp_word_type r;
      @(negedge clock);
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      r = compute_response(w);
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic clear_bars();
      send_word(make_word(bsfc_pkg::REQ_CLEAR, $urandom, $urandom,
                          $urandom_range(0, 1023)));
   endtask

   task automatic append_bar(input logic [bsfc_pkg::PRICE_W-1:0] hi,
                             input logic [bsfc_pkg::PRICE_W-1:0] lo);
      send_word(make_word(bsfc_pkg::REQ_APPEND, hi, lo, $urandom_range(0, 1023)));
   endtask

   task automatic query_bar(input int idx);
      send_word(make_word(bsfc_pkg::REQ_QUERY, $urandom, $urandom, idx));
   endtask

   // price series made of up and down runs, so that both fractal kinds show
   // up often; some steps jump past the bar spread to make gap bars
   task automatic append_trend(input int n);
      logic [bsfc_pkg::PRICE_W-1:0] px;
      logic [bsfc_pkg::PRICE_W-1:0] spread;
      int                           run;
      int                           step;
      bit                           up;
      px  = $urandom_range(1_000_000, 50_000_000);
      up  = ($urandom_range(0, 1) == 1);
      run = 0;
      for (int i = 0; i < n; i++) begin
         if (run == 0) begin
            up  = !up;
            run = $urandom_range(1, 6);
         end
         run--;
         step   = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                              : $urandom_range(0, 60);
         px     = up ? px + step : px - step;
         spread = $urandom_range(0, 120);
         append_bar(px + spread, px);
      end
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   // receiver stalls from a 16-bit pattern, reloaded at each wrap
   always @(negedge clock) begin
      if (!stalls_on) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= stall_pat[stall_phase];
         if (stall_phase == 4'd15) begin
            stall_phase = 4'd0;
            stall_pat   = ($urandom_range(0, 3) == 0) ? (16'($urandom & $urandom) | 16'h8001)
                                                      : (16'($urandom) | 16'h0101);
         end else begin
            stall_phase = stall_phase + 4'd1;
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // every taken result word is checked against the oldest prediction
   always @(posedge clock) begin
      bsfc_pkg::rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result word with none pending", 32'(rsp_word.bar_count), 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_word.bottom_level !== want.bottom_level)
               report_mismatch("bottom_level", 32'(rsp_word.bottom_level),
                               32'(want.bottom_level));
            if (rsp_word.top_level !== want.top_level)
               report_mismatch("top_level", 32'(rsp_word.top_level), 32'(want.top_level));
            if (rsp_word.status !== want.status)
               report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
            if (rsp_word.bar_count !== want.bar_count)
               report_mismatch("bar_count", 32'(rsp_word.bar_count), 32'(want.bar_count));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // empty table queries and the unused code with all-ones and all-zeros fields
   task automatic test_empty_table();
      clear_bars();
      query_bar(1);
      query_bar(0);
      send_word(make_word(REQ_UNUSED, '1, '1, 1023));
      send_word(make_word(REQ_UNUSED, '0, '0, 0));
   endtask

   // hand-built series: a two-level bottom with a gap bar in its forward walk,
   // a two-level top, extreme prices, and every edge of the interior range
   task automatic test_directed_series();
      logic [bsfc_pkg::PRICE_W-1:0] hi_set [10];
      logic [bsfc_pkg::PRICE_W-1:0] lo_set [10];
      hi_set = '{32'hffff_ffff, 5000, 4000, 3000, 3500, 9000, 8500, 3900, 0, 100};
      lo_set = '{32'hffff_fff0, 4000, 3000, 2000, 2500, 8000, 3000, 2900, 0, 50};
      clear_bars();
      append_bar(hi_set[0], lo_set[0]);
      append_bar(hi_set[1], lo_set[1]);
      // fewer than three bars: nothing is interior
      query_bar(1);
      for (int i = 2; i < 10; i++)
         append_bar(hi_set[i], lo_set[i]);
      query_bar(0);
      query_bar(1);
      query_bar(3);
      query_bar(5);
      query_bar(7);
      query_bar(8);
      query_bar(9);
      query_bar(10);
      query_bar(1023);
   endtask

   // mostly short trend series with queries into them, the rest random words
   task automatic test_random_series();
      bsfc_pkg::req_word_type w;
      int                     counted;
      int                     n;
      int                     q;
      counted = 0;
      while (counted < SERIES_ITEMS) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) begin
            n = $urandom_range(3, 40);
            q = $urandom_range(2, 10);
            clear_bars();
            append_trend(n);
            repeat (q) begin
               if ($urandom_range(0, 5) == 0)
                  query_bar($urandom_range(0, 1023));
               else
                  query_bar($urandom_range(1, n - 2));
            end
            counted += 1 + n + q;
         end else begin
            // random words, sometimes aimed at indexes within or just past the filled bars
            repeat ($urandom_range(3, 12)) begin
               w.req_type  = bsfc_pkg::REQ_W'($urandom_range(0, 3));
               w.bar_high  = $urandom;
               w.bar_low   = $urandom;
               w.bar_index = bsfc_pkg::INDEX_W'(($urandom_range(0, 1) == 0)
                                                ? $urandom_range(0, 1023)
                                                : $urandom_range(0, bars_held + 1));
               send_word(w);
               counted++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_directed_series();
      test_random_series();

      @(negedge clock);
      req_valid <= 1'b0;
      // drain, then wait on for any stray word
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0)
         $display("bar_series_fractal_classifier_top verification clean");
      else
         $display("bar_series_fractal_classifier_top verification failed");
      $finish;
   end

   // hang guard, far above the slowest expected run
   initial begin
      #2_000_000;
      $display("bar_series_fractal_classifier_top verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/bsfc_pkg.sv
design/bsfc_bar_store.sv
design/bar_series_fractal_classifier_top.sv
tb/tb.sv
